FILE: design/grs_pkg.sv
// Shared widths for the group reverse stream block.
package grs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GSIZE_W = 5;

endpackage

FILE: design/group_reverse_stream_core.sv
// Top level of the group reverse stream block.
//
// Input channel: in_valid_i / in_stall_o carry one list element per beat,
// value_i with end_of_list_i set on the final element of a list.
// Output channel: out_valid_o / out_stall_i carry one reordered element per
// beat; last_of_run_o marks the final beat caused by one input element and
// list_done_o marks the final beat of a list.
// group_size_i is written when group_size_we_i is high; 0 acts as 1 and
// values above MAX_GROUP act as MAX_GROUP. Write it only while idle.
// Each finished group is drained from one of two banks while the other fills,
// so input takes one beat per cycle until both banks wait to drain.
// Output runs one beat per cycle within a group while out_stall_i is low, with
// an idle gap between groups; the first beat of a group follows the element
// that completed it through the descriptor queue, the registered bank read
// and the output register.
// Reset empties both banks and the queue, clears the output, starts a new
// list and sets the group size to 1. A stalled output holds its beat; the
// drain pauses behind it and input stalls once both banks are full.
module group_reverse_stream_core
  import grs_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               group_size_we_i,
  input  logic [GSIZE_W-1:0] group_size_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               end_of_list_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] out_value_o,
  output logic               last_of_run_o,
  output logic               list_done_o
);

  localparam int unsigned CntW  = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned DescW = CntW + 3;
  localparam int unsigned WrW   = IdxW + VALUE_W + 2;

  logic [GSIZE_W-1:0] group_size_q;
  logic               push;
  logic [DescW-1:0]   push_desc;
  logic               pop;
  logic               desc_valid;
  logic [DescW-1:0]   desc;
  logic [WrW-1:0]     wr;
  logic [1:0]         rel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GSIZE_W'(1);
    end else if (group_size_we_i) begin
      group_size_q <= group_size_i;
    end
  end

  grs_front #(
    .MaxGroup(MAX_GROUP),
    .CntW    (CntW),
    .IdxW    (IdxW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .group_size_i (group_size_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .end_of_list_i(end_of_list_i),
    .push_o       (push),
    .push_desc_o  (push_desc),
    .wr_o         (wr),
    .rel_i        (rel)
  );

  grs_queue #(
    .Width(DescW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_desc),
    .pop_i      (pop),
    .valid_o    (desc_valid),
    .data_o     (desc)
  );

  grs_back #(
    .CntW(CntW),
    .IdxW(IdxW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .pop_o        (pop),
    .rel_o        (rel),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .last_of_run_o(last_of_run_o),
    .list_done_o  (list_done_o)
  );

endmodule

FILE: design/grs_queue.sv
// Two-entry descriptor queue between the group front and the drain back.
module grs_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rptr_q];

endmodule

FILE: design/grs_front.sv
// Input side: fills the group banks and queues a drain descriptor per finished group.
module grs_front
  import grs_pkg::*;
#(
  parameter int unsigned MaxGroup = 16,
  parameter int unsigned CntW     = 5,
  parameter int unsigned IdxW     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [GSIZE_W-1:0]   group_size_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic                 end_of_list_i,
  output logic                 push_o,
  output logic [CntW+2:0]      push_desc_o,
  output logic [IdxW+VALUE_W+1:0] wr_o,
  input  logic [1:0]           rel_i
);

  localparam int unsigned KW = (CntW > GSIZE_W) ? CntW : GSIZE_W;

  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] count;
    logic            rev;
    logic            done;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [IdxW:0]      addr;
    logic [VALUE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  desc_t           desc;
  wr_t             wr;
  rel_t            rel;
  logic [CntW-1:0] fill_q, fill_d;
  logic            first_q, first_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;
  logic [KW-1:0]   k;
  logic [KW-1:0]   fill_inc;
  logic            accept;
  logic            full;

  assign rel = rel_i;

  always_comb begin
    if (group_size_i == '0) begin
      k = KW'(1);
    end else if (KW'(group_size_i) > KW'(MaxGroup)) begin
      k = KW'(MaxGroup);
    end else begin
      k = KW'(group_size_i);
    end
  end

  assign in_stall_o = busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_inc   = KW'(fill_q) + KW'(1);
  assign full       = (fill_inc >= k);

  always_comb begin
    fill_d     = fill_q;
    first_d    = first_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    push_o     = 1'b0;
    desc.bank  = bank_q;
    desc.count = fill_inc[CntW-1:0];
    desc.rev   = 1'b1;
    desc.done  = end_of_list_i;
    if (rel.en) begin
      busy_d[rel.bank] = 1'b0;
    end
    if (accept) begin
      priority if (full) begin
        push_o  = 1'b1;
        first_d = end_of_list_i;
      end else if (end_of_list_i) begin
        push_o   = 1'b1;
        desc.rev = first_q;
        first_d  = 1'b1;
      end else begin
        fill_d = fill_inc[CntW-1:0];
      end
      if (push_o) begin
        fill_d         = '0;
        bank_d         = ~bank_q;
        busy_d[bank_q] = 1'b1;
      end
    end
  end

  assign wr.en   = accept;
  assign wr.addr = {bank_q, fill_q[IdxW-1:0]};
  assign wr.data = value_i;

  assign push_desc_o = desc;
  assign wr_o        = wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      first_q <= 1'b1;
      bank_q  <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      fill_q  <= fill_d;
      first_q <= first_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

FILE: design/grs_back.sv
// Drain side: holds the group banks and emits each queued group, reversed or in order.
module grs_back
  import grs_pkg::*;
#(
  parameter int unsigned CntW = 5,
  parameter int unsigned IdxW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IdxW+VALUE_W+1:0] wr_i,
  input  logic                    desc_valid_i,
  input  logic [CntW+2:0]         desc_i,
  output logic                    pop_o,
  output logic [1:0]              rel_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [VALUE_W-1:0]      out_value_o,
  output logic                    last_of_run_o,
  output logic                    list_done_o
);

  localparam int unsigned MemD = 2 << IdxW;

  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] count;
    logic            rev;
    logic            done;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [IdxW:0]      addr;
    logic [VALUE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  logic [VALUE_W-1:0] mem_q [MemD];
  desc_t              desc;
  wr_t                wr;
  rel_t               rel;

  logic               act_q, act_d;
  logic               bank_q, bank_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    i_q, i_d;
  logic               rev_q, rev_d;
  logic               done_q, done_d;

  logic               r_valid_q, r_valid_d;
  logic               r_last_q;
  logic               r_done_q;
  logic [VALUE_W-1:0] rdata_q;

  logic               o_valid_q, o_valid_d;
  logic               o_last_q;
  logic               o_done_q;
  logic [VALUE_W-1:0] o_value_q;

  logic               r_adv;
  logic               issue;
  logic               is_last;
  logic [CntW-1:0]    idx;
  logic [IdxW:0]      rd_addr;

  assign desc = desc_i;
  assign wr   = wr_i;

  assign r_adv   = r_valid_q && (!o_valid_q || !out_stall_i);
  assign issue   = act_q && (!r_valid_q || r_adv);
  assign is_last = ((i_q + CntW'(1)) == n_q);
  assign idx     = rev_q ? (n_q - CntW'(1) - i_q) : i_q;
  assign rd_addr = {bank_q, idx[IdxW-1:0]};
  assign pop_o   = !act_q && desc_valid_i;

  always_comb begin
    act_d    = act_q;
    bank_d   = bank_q;
    n_d      = n_q;
    i_d      = i_q;
    rev_d    = rev_q;
    done_d   = done_q;
    rel.en   = 1'b0;
    rel.bank = bank_q;
    if (pop_o) begin
      act_d  = 1'b1;
      bank_d = desc.bank;
      n_d    = desc.count;
      i_d    = '0;
      rev_d  = desc.rev;
      done_d = desc.done;
    end else if (issue) begin
      if (is_last) begin
        act_d  = 1'b0;
        rel.en = 1'b1;
      end else begin
        i_d = i_q + CntW'(1);
      end
    end
  end

  assign rel_o = rel;

  always_comb begin
    r_valid_d = r_valid_q;
    o_valid_d = o_valid_q;
    if (issue) begin
      r_valid_d = 1'b1;
    end else if (r_adv) begin
      r_valid_d = 1'b0;
    end
    if (r_adv) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      r_valid_q <= r_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    n_q    <= n_d;
    i_q    <= i_d;
    rev_q  <= rev_d;
    done_q <= done_d;
    if (issue) begin
      r_last_q <= is_last;
      r_done_q <= is_last && done_q;
    end
    if (r_adv) begin
      o_value_q <= rdata_q;
      o_last_q  <= r_last_q;
      o_done_q  <= r_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      mem_q[wr.addr] <= wr.data;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o   = o_valid_q;
  assign out_value_o   = o_value_q;
  assign last_of_run_o = o_last_q;
  assign list_done_o   = o_done_q;

endmodule

FILE: test/group_reverse_stream_core_tb.sv
// Testbench for group_reverse_stream_core: directed table plus random lists, checked by a predictor.
`timescale 1ns / 100ps

module group_reverse_stream_core_tb;
  import grs_pkg::*;

  localparam int unsigned MAX_GROUP   = 16;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CFG_SETTLE  = 16;
  localparam int unsigned PHASE_ITEMS = 58;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               done;
  } beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [GSIZE_W-1:0] size;
    logic [VALUE_W-1:0] value;
    logic               eol;
    bit                 typed;
    beat_t              result;
  } row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               group_size_we_i = 1'b0;
  logic [GSIZE_W-1:0] group_size_i    = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [VALUE_W-1:0] value_i         = '0;
  logic               end_of_list_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [VALUE_W-1:0] out_value_o;
  logic               last_of_run_o;
  logic               list_done_o;

  group_reverse_stream_core #(
    .MAX_GROUP(MAX_GROUP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_size_we_i(group_size_we_i),
    .group_size_i   (group_size_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .end_of_list_i  (end_of_list_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_value_o    (out_value_o),
    .last_of_run_o  (last_of_run_o),
    .list_done_o    (list_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [VALUE_W-1:0] grp_buf [MAX_GROUP];
  int unsigned        grp_fill  = 0;
  bit                 grp_first = 1'b1;
  logic [GSIZE_W-1:0] grp_size  = 1;

  beat_t       run_q[$];
  beat_t       reordered_q[$];
  row_t        rows[$];
  int unsigned errors        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck         = 0;

  function automatic int unsigned group_len();
    if (grp_size == 0) return 1;
    if (grp_size > MAX_GROUP) return MAX_GROUP;
    return grp_size;
  endfunction

  function automatic void flush_group(bit reversed, bit done);
    int unsigned idx;
    beat_t       r;
    for (int unsigned i = 0; i < grp_fill; i++) begin
      idx     = reversed ? grp_fill - 1 - i : i;
      r.value = grp_buf[idx];
      r.last  = (i + 1 == grp_fill);
      r.done  = r.last && done;
      run_q.push_back(r);
    end
    grp_fill = 0;
  endfunction

  function automatic void reorder_element(logic [VALUE_W-1:0] v, bit eol);
    int unsigned k;
    k = group_len();
    run_q.delete();
    if (grp_fill < MAX_GROUP) begin
      grp_buf[grp_fill] = v;
      grp_fill++;
    end
    if (grp_fill >= k) begin
      flush_group(1'b1, eol);
      grp_first = eol;
    end else if (eol) begin
      flush_group(grp_first, 1'b1);
      grp_first = 1'b1;
    end
  endfunction

  function automatic void add_row(row_kind_e kind, logic [GSIZE_W-1:0] size,
                                  logic [VALUE_W-1:0] v, logic eol, bit typed,
                                  logic [VALUE_W-1:0] ev, logic el, logic ed);
    row_t r;
    r.kind   = kind;
    r.size   = size;
    r.value  = v;
    r.eol    = eol;
    r.typed  = typed;
    r.result = '{value: ev, last: el, done: ed};
    rows.push_back(r);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(logic [VALUE_W-1:0] v, logic eol, bit typed, beat_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= v;
    end_of_list_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reorder_element(v, eol);
    if (typed) begin
      reordered_q.push_back(result);
    end else begin
      foreach (run_q[i]) reordered_q.push_back(run_q[i]);
    end
  endtask

  task automatic write_group_size(logic [GSIZE_W-1:0] size);
    in_valid_i <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    group_size_we_i <= 1'b1;
    group_size_i    <= size;
    @(posedge clk_i);
    group_size_we_i <= 1'b0;
    grp_size = size;
  endtask

  task automatic send_lists(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic        eol;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) len = $urandom_range(1, 4);
      else len = $urandom_range(1, 3 * group_len() + 2);
      if (len > n_items - sent) len = n_items - sent;
      for (int unsigned i = 0; i < len; i++) begin
        eol = (i == len - 1);
        if ($urandom_range(15) == 0) eol = 1'($urandom_range(1));
        send_element(pick_value(), eol, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Output side: check beats, stall at random, hold off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reordered_q.size() == 0) begin
        $display("%0t unexpected beat value=%h last=%b done=%b", $time,
                 out_value_o, last_of_run_o, list_done_o);
        errors++;
      end else begin
        if (out_value_o !== reordered_q[0].value) begin
          $display("%0t out_value expected %h actual %h", $time,
                   reordered_q[0].value, out_value_o);
          errors++;
        end
        if (last_of_run_o !== reordered_q[0].last) begin
          $display("%0t last_of_run expected %b actual %b", $time,
                   reordered_q[0].last, last_of_run_o);
          errors++;
        end
        if (list_done_o !== reordered_q[0].done) begin
          $display("%0t list_done expected %b actual %b", $time,
                   reordered_q[0].done, list_done_o);
          errors++;
        end
        void'(reordered_q.pop_front());
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [GSIZE_W-1:0] sizes [8];
    int unsigned        mode;

    // reset value of group size is 1: each element passes straight through
    add_row(ROW_BEAT, 0, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_row(ROW_BEAT, 0, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b1);
    add_row(ROW_BEAT, 0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    add_row(ROW_BEAT, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // zero size acts as one
    add_row(ROW_CFG,  0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b1, 1'b1);
    // partial first group, full group, partial later group, full group at end
    add_row(ROW_CFG,  3, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 1,  1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 2,  1'b1, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 10, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 20, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 30, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 40, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 50, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 60, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 70, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 80, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // lower the size while a group is half full
    add_row(ROW_BEAT, 0, 5, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 6, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_CFG,  2, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 8, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // oversize saturates; a lone element is its own first group
    add_row(ROW_CFG,  31, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ROW_BEAT, 0, 32'hFFFF_FFFB, 1'b1, 1'b1, 32'hFFFF_FFFB, 1'b1, 1'b1);

    sizes = '{16, 1, 3, 0, 31, GSIZE_W'($urandom_range(2, 8)),
              GSIZE_W'($urandom_range(5, 15)), 2};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_group_size(rows[i].size);
      else send_element(rows[i].value, rows[i].eol, rows[i].typed, rows[i].result);
    end

    for (int unsigned p = 0; p < 8; p++) begin
      write_group_size(sizes[p]);
      mode = p % 4;
      send_idle_pct  <= (mode == 1) ? 87 : (mode == 3) ? 7 : 0;
      recv_stall_pct <= (mode == 2) ? 87 : (mode == 3) ? 7 : 0;
      if (p == 0) hold_reqs <= hold_reqs + 1;
      @(posedge clk_i);
      send_lists(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    if (errors == 0 && reordered_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
